// File: design/sip_pkg.sv
package sip_pkg;

    // Fixed widths of the item fields.
    localparam int CHAR_W   = 8;
    localparam int OFFSET_W = 12;
    localparam int STATUS_W = 2;

    // Every pool record opens with a little-endian 16-bit length header.
    localparam int HDR_BYTES = 2;
    localparam int HL_W      = 16;

    localparam int POOL_BYTES_DEF       = 4096;
    localparam int MAX_STRING_BYTES_DEF = 256;

    localparam logic [STATUS_W-1:0] STATUS_FOUND = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ADDED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_LONG  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK,
        ST_HDR_LO,
        ST_HDR_HI,
        ST_CMP,
        ST_APP_LO,
        ST_APP_HI,
        ST_APP_BODY,
        ST_RESULT
    } sip_state_t;

    // Commands from the sequencer to the string buffer.
    typedef struct packed {
        logic push;
        logic clear;
    } sip_buf_cmd_t;

endpackage

// File: design/sip_char_if.sv
interface sip_char_if;
    logic                       valid;
    logic                       ready;
    logic [sip_pkg::CHAR_W-1:0] char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink   (input valid, input char_byte, output ready);
endinterface

// File: design/sip_result_if.sv
interface sip_result_if;
    logic                         valid;
    logic                         ready;
    logic [sip_pkg::OFFSET_W-1:0] string_offset;
    logic [sip_pkg::STATUS_W-1:0] status;

    modport source (output valid, output string_offset, output status, input ready);
    modport sink   (input valid, input string_offset, input status, output ready);
endinterface

// File: design/sip_string_buf.sv
module sip_string_buf #(
    parameter int MAX_STRING_BYTES = sip_pkg::MAX_STRING_BYTES_DEF,
    localparam int IW = (MAX_STRING_BYTES > 1) ? $clog2(MAX_STRING_BYTES) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sip_pkg::sip_buf_cmd_t      cmd,
    input  logic [sip_pkg::CHAR_W-1:0] push_byte,
    input  logic [IW-1:0]              rd_idx,
    output logic [sip_pkg::CHAR_W-1:0] rd_data,
    output logic [IW-1:0]              length,
    output logic                       overflow
);
    import sip_pkg::*;

    logic [CHAR_W-1:0] buf_mem [MAX_STRING_BYTES];
    logic [CHAR_W-1:0] rd_data_reg;
    logic [IW-1:0]     length_reg, length_next;
    logic              overflow_reg, overflow_next;
    logic              has_room;
    logic              wr_en;

    // One place is kept back for the terminator.
    assign has_room = length_reg < IW'(MAX_STRING_BYTES - 1);
    assign wr_en    = cmd.push && has_room;

    always_comb
    begin
        length_next   = length_reg;
        overflow_next = overflow_reg;
        if (cmd.clear)
        begin
            length_next   = '0;
            overflow_next = 1'b0;
        end
        else if (cmd.push)
        begin
            if (has_room)
            begin
                length_next = length_reg + 1'b1;
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg   <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            length_reg   <= length_next;
            overflow_reg <= overflow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            buf_mem[length_reg] <= push_byte;
        end
        rd_data_reg <= buf_mem[rd_idx];
    end

    assign rd_data  = rd_data_reg;
    assign length   = length_reg;
    assign overflow = overflow_reg;

endmodule

// File: design/string_intern_pool.sv
// Flow: a byte other than zero is pushed into the string buffer and ready stays high.
// A terminator starts a walk of the pool: each record passed has its two header bytes read,
// a record of equal length has its body compared byte by byte, then a new record is
// appended as its two header bytes and body, and the result goes to the output register.
// Throughput: one byte per cycle when idle; the single read port limits the walk.
// Reset: the pool fill level, string length and overflow flag clear; memories do not.
module string_intern_pool #(
    parameter int POOL_BYTES       = sip_pkg::POOL_BYTES_DEF,
    parameter int MAX_STRING_BYTES = sip_pkg::MAX_STRING_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    sip_char_if.sink            char_in,
    sip_result_if.source        result_out
);
    import sip_pkg::*;

    // Widths that follow from the parameters.
    localparam int AW   = $clog2(POOL_BYTES);
    localparam int FW   = $clog2(POOL_BYTES + 1);
    localparam int IW   = (MAX_STRING_BYTES > 1) ? $clog2(MAX_STRING_BYTES) : 1;
    localparam int LW   = $clog2(MAX_STRING_BYTES + 1);
    localparam int SUMW = ((FW > LW) ? FW : LW) + 2;
    localparam int PW   = ((FW > HL_W) ? FW : HL_W) + 2;

    // The pool itself: a one-write, one-read memory with a registered read.
    logic [CHAR_W-1:0] pool_mem [POOL_BYTES];
    logic [CHAR_W-1:0] pool_rdata_reg;
    logic [AW-1:0]     pool_raddr;
    logic [AW-1:0]     pool_waddr;
    logic [CHAR_W-1:0] pool_wdata;
    logic              pool_we;

    sip_state_t state_reg, state_next;

    logic [FW-1:0]       pos_reg, pos_next;
    logic [FW-1:0]       body_reg, body_next;
    logic [FW-1:0]       fill_end_reg, fill_end_next;
    logic [CHAR_W-1:0]   lo_reg, lo_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [OFFSET_W-1:0] res_offset_reg, res_offset_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [OFFSET_W-1:0] out_offset_reg, out_offset_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    // String buffer signals.
    sip_buf_cmd_t      buf_cmd;
    logic [IW-1:0]     buf_rd_idx;
    logic [CHAR_W-1:0] buf_rd_data;
    logic [IW-1:0]     len_in;
    logic              overflow;

    // Decoded conditions.
    logic              in_beat;
    logic              is_term;
    logic [LW-1:0]     len;
    logic [HL_W-1:0]   hl;
    logic              walk_done;
    logic [SUMW-1:0]   need_end;
    logic              fits;
    logic [PW-1:0]     next_rec;
    logic              last_byte;
    logic [CHAR_W-1:0] want_byte;
    logic              byte_match;
    logic              out_free;
    logic [HL_W-1:0]   len_hdr;

    sip_string_buf #(
        .MAX_STRING_BYTES (MAX_STRING_BYTES)
    ) u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (buf_cmd),
        .push_byte (char_in.char_byte),
        .rd_idx    (buf_rd_idx),
        .rd_data   (buf_rd_data),
        .length    (len_in),
        .overflow  (overflow)
    );

    assign in_beat = char_in.valid && char_in.ready;
    assign is_term = (char_in.char_byte == '0);

    // The terminator counts toward the length.
    assign len     = LW'(len_in) + 1'b1;
    assign len_hdr = HL_W'(len);

    // The header word of the record under the walk: high byte from the memory, low held.
    assign hl        = {pool_rdata_reg, lo_reg};
    assign walk_done = (pos_reg >= fill_end_reg);
    assign next_rec  = PW'(pos_reg) + PW'(HDR_BYTES) + PW'(hl);

    // Room check counts the two header bytes as well as the body.
    assign need_end = SUMW'(fill_end_reg) + SUMW'(HDR_BYTES) + SUMW'(len);
    assign fits     = (need_end <= SUMW'(POOL_BYTES));

    // The last body byte is the terminator, which the buffer never stores.
    assign last_byte  = (idx_reg == len_in);
    assign want_byte  = last_byte ? '0 : buf_rd_data;
    assign byte_match = (pool_rdata_reg == want_byte);

    assign out_free = !out_valid_reg || result_out.ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat && is_term)
                begin
                    state_next = overflow ? ST_RESULT : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_done)
                begin
                    state_next = fits ? ST_APP_LO : ST_RESULT;
                end
                else
                begin
                    state_next = ST_HDR_LO;
                end
            end
            ST_HDR_LO:
            begin
                state_next = ST_HDR_HI;
            end
            ST_HDR_HI:
            begin
                state_next = (hl == len_hdr) ? ST_CMP : ST_WALK;
            end
            ST_CMP:
            begin
                if (!byte_match)
                begin
                    state_next = ST_WALK;
                end
                else if (last_byte)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_APP_LO:
            begin
                state_next = ST_APP_HI;
            end
            ST_APP_HI:
            begin
                state_next = ST_APP_BODY;
            end
            ST_APP_BODY:
            begin
                if (last_byte)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and handshake outputs.
    always_comb
    begin
        pos_next        = pos_reg;
        body_next       = body_reg;
        fill_end_next   = fill_end_reg;
        lo_next         = lo_reg;
        idx_next        = idx_reg;
        res_offset_next = res_offset_reg;
        res_status_next = res_status_reg;
        out_offset_next = out_offset_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !result_out.ready;

        pool_raddr = AW'(pos_reg);
        pool_waddr = AW'(fill_end_reg);
        pool_wdata = len_hdr[7:0];
        pool_we    = 1'b0;

        buf_rd_idx    = idx_reg;
        buf_cmd.push  = 1'b0;
        buf_cmd.clear = 1'b0;

        char_in.ready = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (!is_term)
                    begin
                        buf_cmd.push = 1'b1;
                    end
                    else
                    begin
                        pos_next        = '0;
                        res_offset_next = '0;
                        res_status_next = STATUS_LONG;
                    end
                end
            end
            ST_WALK:
            begin
                // Issue the read of the header's low byte.
                pool_raddr = AW'(pos_reg);
                if (walk_done && !fits)
                begin
                    res_offset_next = '0;
                    res_status_next = STATUS_FULL;
                end
            end
            ST_HDR_LO:
            begin
                pool_raddr = AW'(pos_reg + 1'b1);
                lo_next    = pool_rdata_reg;
            end
            ST_HDR_HI:
            begin
                body_next  = FW'(pos_reg + FW'(HDR_BYTES));
                idx_next   = '0;
                pool_raddr = AW'(pos_reg + FW'(HDR_BYTES));
                buf_rd_idx = '0;
                pos_next   = FW'(next_rec);
            end
            ST_CMP:
            begin
                // Compare this byte while the next pair of reads is issued.
                idx_next   = idx_reg + 1'b1;
                buf_rd_idx = idx_reg + 1'b1;
                pool_raddr = AW'(body_reg + FW'(idx_reg) + 1'b1);
                if (byte_match && last_byte)
                begin
                    res_offset_next = OFFSET_W'(body_reg);
                    res_status_next = STATUS_FOUND;
                end
            end
            ST_APP_LO:
            begin
                pool_we    = 1'b1;
                pool_waddr = AW'(fill_end_reg);
                pool_wdata = len_hdr[7:0];
            end
            ST_APP_HI:
            begin
                pool_we    = 1'b1;
                pool_waddr = AW'(fill_end_reg + 1'b1);
                pool_wdata = len_hdr[15:8];
                body_next  = FW'(fill_end_reg + FW'(HDR_BYTES));
                idx_next   = '0;
                buf_rd_idx = '0;
            end
            ST_APP_BODY:
            begin
                pool_we    = 1'b1;
                pool_waddr = AW'(body_reg + FW'(idx_reg));
                pool_wdata = want_byte;
                idx_next   = idx_reg + 1'b1;
                buf_rd_idx = idx_reg + 1'b1;
                if (last_byte)
                begin
                    fill_end_next   = FW'(body_reg + FW'(len));
                    res_offset_next = OFFSET_W'(body_reg);
                    res_status_next = STATUS_ADDED;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_offset_next = res_offset_reg;
                    out_status_next = res_status_reg;
                    buf_cmd.clear   = 1'b1;
                end
            end
            default:
            begin
                pool_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_end_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_end_reg  <= fill_end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers of the walk carry no reset.
    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        body_reg       <= body_next;
        lo_reg         <= lo_next;
        idx_reg        <= idx_next;
        res_offset_reg <= res_offset_next;
        res_status_reg <= res_status_next;
        out_offset_reg <= out_offset_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (pool_we)
        begin
            pool_mem[pool_waddr] <= pool_wdata;
        end
        pool_rdata_reg <= pool_mem[pool_raddr];
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.string_offset = out_offset_reg;
    assign result_out.status        = out_status_reg;

endmodule
